/* sv/aat_pkg.sv */
`timescale 1ns / 1ps

package aat_pkg;

    localparam int NUM_AXES   = 3;
    localparam int NUM_REGS   = 6;
    localparam int NUM_STAGES = 4;
    localparam int FIX_W      = 32;
    localparam int PROD_W     = 2 * FIX_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_BITS  = 16;
    localparam int SHR_W      = ACC_W - FRAC_BITS;
    localparam int REG_W      = 64;
    localparam int IDX_W      = 3;

    typedef logic signed [FIX_W-1:0]  t_fix;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PAIR_W-1:0] t_pair;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [REG_W-1:0]         t_reg;

    typedef enum logic [IDX_W-1:0] {
        REG_X_LO = 3'd0,
        REG_X_HI = 3'd1,
        REG_Y_LO = 3'd2,
        REG_Y_HI = 3'd3,
        REG_Z_LO = 3'd4,
        REG_Z_HI = 3'd5
    } t_reg_idx;

    localparam t_reg RST_X_LO = 64'h0000_0000_0001_0000;
    localparam t_reg RST_X_HI = 64'h0000_0000_0000_0000;
    localparam t_reg RST_Y_LO = 64'h0001_0000_0000_0000;
    localparam t_reg RST_Y_HI = 64'h0000_0000_0000_0000;
    localparam t_reg RST_Z_LO = 64'h0000_0000_0000_0000;
    localparam t_reg RST_Z_HI = 64'h0000_0000_0001_0000;

    localparam t_fix FIX_MAX = 32'sh7FFF_FFFF;
    localparam t_fix FIX_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

endpackage

/* sv/aat_cfg.sv */
`timescale 1ns / 1ps

module aat_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  logic [aat_pkg::IDX_W-1:0]   i_idx,
    input  aat_pkg::t_reg               i_data,
    output aat_pkg::t_fix               o_coef [aat_pkg::NUM_AXES][aat_pkg::NUM_AXES],
    output aat_pkg::t_fix               o_trans [aat_pkg::NUM_AXES]
);

    aat_pkg::t_reg r_reg [aat_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg[aat_pkg::REG_X_LO] <= aat_pkg::RST_X_LO;
            r_reg[aat_pkg::REG_X_HI] <= aat_pkg::RST_X_HI;
            r_reg[aat_pkg::REG_Y_LO] <= aat_pkg::RST_Y_LO;
            r_reg[aat_pkg::REG_Y_HI] <= aat_pkg::RST_Y_HI;
            r_reg[aat_pkg::REG_Z_LO] <= aat_pkg::RST_Z_LO;
            r_reg[aat_pkg::REG_Z_HI] <= aat_pkg::RST_Z_HI;
        end else if (i_wr) begin
            case (aat_pkg::t_reg_idx'(i_idx))
                aat_pkg::REG_X_LO: r_reg[aat_pkg::REG_X_LO] <= i_data;
                aat_pkg::REG_X_HI: r_reg[aat_pkg::REG_X_HI] <= i_data;
                aat_pkg::REG_Y_LO: r_reg[aat_pkg::REG_Y_LO] <= i_data;
                aat_pkg::REG_Y_HI: r_reg[aat_pkg::REG_Y_HI] <= i_data;
                aat_pkg::REG_Z_LO: r_reg[aat_pkg::REG_Z_LO] <= i_data;
                aat_pkg::REG_Z_HI: r_reg[aat_pkg::REG_Z_HI] <= i_data;
                default: ;
            endcase
        end
    end

    // per axis: lo word holds coefficients 0 and 1, hi word holds coefficient 2 and translation
    for (genvar a = 0; a < aat_pkg::NUM_AXES; a++) begin : g_axis
        assign o_coef[a][0] = r_reg[2*a][31:0];
        assign o_coef[a][1] = r_reg[2*a][63:32];
        assign o_coef[a][2] = r_reg[2*a+1][31:0];
        assign o_trans[a]   = r_reg[2*a+1][63:32];
    end

endmodule

/* sv/aat_ctrl.sv */
`timescale 1ns / 1ps

module aat_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output aat_pkg::t_pipe_ctl o_ctl
);

    logic [aat_pkg::NUM_STAGES-1:0] r_vld;
    logic [aat_pkg::NUM_STAGES-1:0] n_vld;
    logic [aat_pkg::NUM_STAGES-1:0] w_rdy;

    always_comb begin
        w_rdy[aat_pkg::NUM_STAGES-1] = !r_vld[aat_pkg::NUM_STAGES-1] || i_m_tready;
        for (int s = aat_pkg::NUM_STAGES - 2; s >= 0; s--) begin
            w_rdy[s] = !r_vld[s] || w_rdy[s+1];
        end
        n_vld = r_vld;
        if (w_rdy[0]) begin
            n_vld[0] = i_s_tvalid;
        end
        for (int s = 1; s < aat_pkg::NUM_STAGES; s++) begin
            if (w_rdy[s]) begin
                n_vld[s] = r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.en   = w_rdy;
    assign o_s_tready = w_rdy[0];
    assign o_m_tvalid = r_vld[aat_pkg::NUM_STAGES-1];

endmodule

/* sv/aat_axis.sv */
`timescale 1ns / 1ps

module aat_axis (
    input  logic               i_clk,
    input  aat_pkg::t_pipe_ctl i_ctl,
    input  aat_pkg::t_fix      i_mn [aat_pkg::NUM_AXES],
    input  aat_pkg::t_fix      i_mx [aat_pkg::NUM_AXES],
    input  aat_pkg::t_fix      i_coef [aat_pkg::NUM_AXES],
    input  aat_pkg::t_fix      i_trans,
    output aat_pkg::t_fix      o_lo,
    output aat_pkg::t_fix      o_hi
);

    aat_pkg::t_prod r_p [aat_pkg::NUM_AXES];
    aat_pkg::t_prod r_q [aat_pkg::NUM_AXES];
    aat_pkg::t_prod r_lo [aat_pkg::NUM_AXES];
    aat_pkg::t_prod r_hi [aat_pkg::NUM_AXES];
    aat_pkg::t_pair r_lo_a, r_lo_b, r_hi_a, r_hi_b;
    aat_pkg::t_fix  r_out_lo, r_out_hi;

    aat_pkg::t_prod w_tsh;
    aat_pkg::t_acc  w_lo_sum, w_hi_sum;
    logic signed [aat_pkg::SHR_W-1:0] w_lo_shr, w_hi_shr;

    function automatic aat_pkg::t_pair ext_pair(input aat_pkg::t_prod v);
        return {v[aat_pkg::PROD_W-1], v};
    endfunction

    function automatic aat_pkg::t_acc ext_acc(input aat_pkg::t_pair v);
        return {v[aat_pkg::PAIR_W-1], v};
    endfunction

    function automatic aat_pkg::t_fix sat(input logic signed [aat_pkg::SHR_W-1:0] v);
        logic [aat_pkg::SHR_W-aat_pkg::FIX_W:0] top;
        top = v[aat_pkg::SHR_W-1:aat_pkg::FIX_W-1];
        if (top == '0 || top == '1) begin
            return v[aat_pkg::FIX_W-1:0];
        end else if (v[aat_pkg::SHR_W-1]) begin
            return aat_pkg::FIX_MIN;
        end else begin
            return aat_pkg::FIX_MAX;
        end
    endfunction

    // stage 1: corner products
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            for (int k = 0; k < aat_pkg::NUM_AXES; k++) begin
                r_p[k] <= i_coef[k] * i_mn[k];
                r_q[k] <= i_coef[k] * i_mx[k];
            end
        end
    end

    // stage 2: per-term min and max
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            for (int k = 0; k < aat_pkg::NUM_AXES; k++) begin
                r_lo[k] <= (r_p[k] < r_q[k]) ? r_p[k] : r_q[k];
                r_hi[k] <= (r_p[k] < r_q[k]) ? r_q[k] : r_p[k];
            end
        end
    end

    // stage 3: partial sums, translation scaled to the product format
    assign w_tsh = {{(aat_pkg::PROD_W-aat_pkg::FIX_W-aat_pkg::FRAC_BITS){i_trans[aat_pkg::FIX_W-1]}},
                    i_trans, {aat_pkg::FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_lo_a <= ext_pair(r_lo[0]) + ext_pair(r_lo[1]);
            r_lo_b <= ext_pair(r_lo[2]) + ext_pair(w_tsh);
            r_hi_a <= ext_pair(r_hi[0]) + ext_pair(r_hi[1]);
            r_hi_b <= ext_pair(r_hi[2]) + ext_pair(w_tsh);
        end
    end

    // stage 4: final sum, floor shift, saturate
    assign w_lo_sum = ext_acc(r_lo_a) + ext_acc(r_lo_b);
    assign w_hi_sum = ext_acc(r_hi_a) + ext_acc(r_hi_b);
    assign w_lo_shr = w_lo_sum[aat_pkg::ACC_W-1:aat_pkg::FRAC_BITS];
    assign w_hi_shr = w_hi_sum[aat_pkg::ACC_W-1:aat_pkg::FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_out_lo <= sat(w_lo_shr);
            r_out_hi <= sat(w_hi_shr);
        end
    end

    assign o_lo = r_out_lo;
    assign o_hi = r_out_hi;

endmodule

/* sv/aabb_affine_transform_top.sv */
`timescale 1ns / 1ps

// Transforms an axis-aligned box (signed Q16.16 min and max corners) by the
// affine matrix held in six 64-bit configuration registers and returns the
// bounding box of the result, floored to Q16.16 and saturated to 32 bits.
// The block accepts one box every cycle unless backpressure fills the pipeline
// and passes it through a 32x32 multiply stage (eighteen multipliers), a
// min/max select stage, a partial-add stage, and a final add with floor
// shift and saturation that feeds the output register. Backpressure stalls the
// pipeline without losing data; bubbles are squeezed out. Registers reset to
// the identity transform and take effect on the cycle after the write; the
// configuration channel is always ready and writes to indexes six and seven
// are dropped. Write configuration only while no box is in flight.
module aabb_affine_transform_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [191:0]                i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic [191:0]                o_m_tdata,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [aat_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [aat_pkg::REG_W-1:0]   i_cfg_data
);

    localparam int FW = aat_pkg::FIX_W;
    localparam int NA = aat_pkg::NUM_AXES;

    aat_pkg::t_fix      w_mn [NA];
    aat_pkg::t_fix      w_mx [NA];
    aat_pkg::t_fix      w_coef [NA][NA];
    aat_pkg::t_fix      w_trans [NA];
    aat_pkg::t_fix      w_lo [NA];
    aat_pkg::t_fix      w_hi [NA];
    aat_pkg::t_pipe_ctl w_ctl;

    assign o_cfg_ready = 1'b1;

    aat_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_coef  (w_coef),
        .o_trans (w_trans)
    );

    aat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_ctl      (w_ctl)
    );

    for (genvar k = 0; k < NA; k++) begin : g_unpack
        assign w_mn[k] = i_s_tdata[k*FW +: FW];
        assign w_mx[k] = i_s_tdata[(k+NA)*FW +: FW];
        assign o_m_tdata[k*FW +: FW]      = w_lo[k];
        assign o_m_tdata[(k+NA)*FW +: FW] = w_hi[k];
    end

    for (genvar a = 0; a < NA; a++) begin : g_axis
        aat_axis u_axis (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_mn    (w_mn),
            .i_mx    (w_mx),
            .i_coef  (w_coef[a]),
            .i_trans (w_trans[a]),
            .o_lo    (w_lo[a]),
            .o_hi    (w_hi[a])
        );
    end

endmodule
